// File: design/rrco_pkg.sv
// shared types and constants for the ring read cursor with overrun recovery
// no dependencies; imported by every module of the block
`default_nettype none

package rrco_pkg;

    localparam int unsigned MAX_SIZE_LOG2_DEF = 16;
    localparam int unsigned CFG_W             = 5;
    localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 5'd12;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned HEAD_W    = 16;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 104;

    typedef enum logic [OP_W-1:0] {
        OP_HEAD    = 2'd0,
        OP_CONSUME = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CNT_W-1:0]   byte_count;
        logic [HEAD_W-1:0]  head_index;
    } t_item;

    // first field in the highest bits
    typedef struct packed {
        logic [TOTAL_W-1:0] overrun_total;
        logic               overrun_seen;
        logic [CNT_W-1:0]   available_now;
        logic [HEAD_W-1:0]  start_index;
        logic [CNT_W-1:0]   granted_count;
        logic [CNT_W-1:0]   unread_after_head;
    } t_result;

endpackage

`default_nettype wire

// File: design/rrco_in_stage.sv
// input register of the ring read cursor
// uses rrco_pkg; holds one word until the cursor takes it
`default_nettype none

module rrco_in_stage import rrco_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/rrco_cursor.sv
// cursor state and combinational update for head reports, consume, peek and clear
// uses rrco_pkg; result is combinational, state commits when i_fire is high
`default_nettype none

module rrco_cursor import rrco_pkg::*; #(
    parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire t_item            i_item,
    input  wire logic [CFG_W-1:0] i_size_log2,
    output t_result               o_result
);

    localparam int unsigned POS_W = MAX_SIZE_LOG2;
    localparam int unsigned CAP_W = MAX_SIZE_LOG2 + 1;
    localparam int unsigned HX_W  = (POS_W > HEAD_W) ? POS_W : HEAD_W;
    localparam int unsigned GW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int unsigned LG_W  = CFG_W + 1;

    logic [POS_W-1:0]   r_prev_head, n_prev_head;
    logic [POS_W-1:0]   r_read_pos,  n_read_pos;
    logic [ACC_W-1:0]   r_written,   n_written;
    logic [ACC_W-1:0]   r_read,      n_read;
    logic [ACC_W-1:0]   r_unread,    n_unread;
    logic [TOTAL_W-1:0] r_overrun,   n_overrun;

    logic [LG_W-1:0]  lg;
    logic [CAP_W-1:0] cap, quarter, margin, av, consume_avail, avail_sel;
    logic [POS_W-1:0] mask, h, delta, start, over_pos, consume_pos;
    logic [HX_W-1:0]  head_x, start_x;
    logic [ACC_W-1:0] written_inc, diff, head_unread, over_read, consume_unread, unread_sel;
    logic [GW-1:0]    req_x, av_x, grant_x, avail_x;
    logic [CNT_W-1:0] grant, grant_out, unread_out;
    logic             over, seen;

    // ring geometry
    always_comb begin
        if ({1'b0, i_size_log2} > LG_W'(MAX_SIZE_LOG2)) begin
            lg = LG_W'(MAX_SIZE_LOG2);
        end else begin
            lg = {1'b0, i_size_log2};
        end
        cap     = CAP_W'(1) << lg;
        mask    = POS_W'(cap - CAP_W'(1));
        quarter = cap >> 2;
        margin  = (quarter == '0) ? CAP_W'(1) : quarter;
    end

    // head report path
    assign head_x      = HX_W'(i_item.head_index);
    assign h           = head_x[POS_W-1:0] & mask;
    assign delta       = (h - (r_prev_head & mask)) & mask;
    assign written_inc = r_written + ACC_W'(delta);
    assign diff        = written_inc - r_read;
    assign head_unread = (written_inc >= r_read) ? diff : '0;
    assign over        = head_unread > ACC_W'(cap);
    assign over_read   = written_inc - ACC_W'(margin);
    assign over_pos    = POS_W'(CAP_W'(h) - margin) & mask;

    // consume and peek path
    assign start          = r_read_pos & mask;
    assign av             = (r_unread > ACC_W'(cap)) ? cap : r_unread[CAP_W-1:0];
    assign req_x          = GW'(i_item.byte_count);
    assign av_x           = GW'(av);
    assign grant_x        = (req_x > av_x) ? av_x : req_x;
    assign grant          = grant_x[CNT_W-1:0];
    assign consume_unread = r_unread - ACC_W'(grant);
    assign consume_avail  = (consume_unread > ACC_W'(cap)) ? cap
                                                           : consume_unread[CAP_W-1:0];
    assign consume_pos    = POS_W'(GW'(start) + GW'(grant)) & mask;

    always_comb begin
        n_prev_head = r_prev_head;
        n_read_pos  = r_read_pos;
        n_written   = r_written;
        n_read      = r_read;
        n_unread    = r_unread;
        n_overrun   = r_overrun;
        unread_sel  = '0;
        grant_out   = '0;
        avail_sel   = '0;
        seen        = 1'b0;
        unread_sel  = over ? ACC_W'(margin) : head_unread;
        unique case (i_item.op)
            OP_HEAD: begin
                n_prev_head = h;
                n_written   = written_inc;
                n_unread    = unread_sel;
                avail_sel   = unread_sel[CAP_W-1:0];
                seen        = over;
                if (over) begin
                    n_read     = over_read;
                    n_read_pos = over_pos;
                    n_overrun  = r_overrun + TOTAL_W'(1);
                end
            end
            OP_CONSUME: begin
                grant_out = grant;
                avail_sel = consume_avail;
                if (grant != '0) begin
                    n_read     = r_read + ACC_W'(grant);
                    n_read_pos = consume_pos;
                    n_unread   = consume_unread;
                end
            end
            OP_PEEK: begin
                grant_out = grant;
                avail_sel = av;
            end
            OP_CLEAR: begin
                n_prev_head = '0;
                n_read_pos  = '0;
                n_written   = '0;
                n_read      = '0;
                n_unread    = '0;
                n_overrun   = '0;
            end
            default: begin
                avail_sel = '0;
            end
        endcase
    end

    assign start_x    = HX_W'(start);
    assign avail_x    = GW'(avail_sel);
    assign unread_out = (i_item.op == OP_HEAD) ? unread_sel[CNT_W-1:0] : '0;

    always_comb begin
        o_result.unread_after_head = unread_out;
        o_result.granted_count     = grant_out;
        o_result.start_index       = start_x[HEAD_W-1:0];
        o_result.available_now     = avail_x[CNT_W-1:0];
        o_result.overrun_seen      = seen;
        o_result.overrun_total     = n_overrun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_head <= '0;
            r_read_pos  <= '0;
            r_written   <= '0;
            r_read      <= '0;
            r_unread    <= '0;
            r_overrun   <= '0;
        end else if (i_fire) begin
            r_prev_head <= n_prev_head;
            r_read_pos  <= n_read_pos;
            r_written   <= n_written;
            r_read      <= n_read;
            r_unread    <= n_unread;
            r_overrun   <= n_overrun;
        end
    end

endmodule

`default_nettype wire

// File: design/rrco_out_stage.sv
// result register of the ring read cursor
// uses rrco_pkg; holds one result word until the sink takes it
`default_nettype none

module rrco_out_stage import rrco_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_can_load,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: design/ring_read_cursor_overrun_core.sv
// ring read cursor with overrun recovery: top level
// uses rrco_pkg, rrco_in_stage, rrco_cursor and rrco_out_stage
//
// words arrive on the s_axis stream: tuser carries the operation (head report,
// consume, peek, clear), tdata the producer head index and the requested byte
// count. every word gives exactly one result word on m_axis: unread count after
// a head report, granted count, start index, available count, overrun flag and
// overrun total.
// ring capacity is set by i_cfg_wr_en / i_cfg_wr_data (log2 of bytes, reset 12),
// written only while no word is in flight; the user must ensure this, the block
// does not. a word waits in the input register until it fires and its cursor
// result is registered. one word per cycle is sustained while m_axis_tready is
// high; the cursor state (64-bit written and read totals, tail, overrun count)
// is updated as each word fires, so each word sees the state its predecessor
// left. a synchronous active-low reset empties both registers and zeroes the
// cursor state. when the sink holds m_axis_tready low the result register stays
// put; the input register still takes one more word, then s_axis_tready falls.
`default_nettype none

module ring_read_cursor_overrun_core import rrco_pkg::*; #(
    parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]     i_cfg_wr_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // head_index [15:0], byte_count [32:16], zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // op [1:0]
    input  wire logic [OP_W-1:0]      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // unread_after_head [16:0], granted_count [33:17], start_index [49:34],
    // available_now [66:50], overrun_seen [67], overrun_total [99:68], zero fill
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    logic [CFG_W-1:0] r_size_log2;
    t_item            w_in_item;
    t_item            w_item;
    logic             w_item_valid;
    logic             w_can_load;
    logic             w_fire;
    t_result          w_result;
    t_result          w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_LOG2_RST;
        end else if (i_cfg_wr_en) begin
            r_size_log2 <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_in_item.op         = t_op'(s_axis_tuser);
        w_in_item.byte_count = s_axis_tdata[HEAD_W+CNT_W-1:HEAD_W];
        w_in_item.head_index = s_axis_tdata[HEAD_W-1:0];
    end

    assign w_fire = w_item_valid && w_can_load;

    rrco_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    rrco_cursor #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .i_size_log2 (r_size_log2),
        .o_result    (w_result)
    );

    rrco_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_out)
    );

    assign m_axis_tdata = {(M_TDATA_W - $bits(t_result))'(0), w_out};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending right after reset");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_item.op == OP_CLEAR |=>
            m_axis_tvalid && w_out.overrun_total == '0 && w_out.available_now == '0)
        else $error("clear did not zero the cursor state");

    a_overrun_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_out.overrun_seen |->
            w_out.available_now == w_out.unread_after_head && w_out.granted_count == '0)
        else $error("overrun result does not report the margin");

endmodule

`default_nettype wire

// File: bench/rrco_checker.sv
// checker for the ring read cursor: watches the config port and both streams,
// predicts each result word from its own cursor state and compares field by field
// depends on rrco_pkg
module rrco_checker import rrco_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [OP_W-1:0]      i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_overruns
);

    localparam int unsigned MAX_LOG2 = MAX_SIZE_LOG2_DEF;

    // cursor state as the block should hold it
    logic [CFG_W-1:0]   ring_log2;
    logic [HEAD_W-1:0]  producer_head;
    logic [ACC_W-1:0]   written_bytes;
    logic [ACC_W-1:0]   consumed_bytes;
    logic [HEAD_W-1:0]  tail;
    logic [TOTAL_W-1:0] overrun_ctr;

    t_result predicted_reports[$];
    int      mismatches;
    int      compared;
    int      recoveries;

    function automatic logic [63:0] unread_bytes();
        return (written_bytes >= consumed_bytes) ? written_bytes - consumed_bytes : 64'd0;
    endfunction

    task automatic clear_cursor();
        producer_head  = '0;
        written_bytes  = '0;
        consumed_bytes = '0;
        tail           = '0;
        overrun_ctr    = '0;
    endtask

    task automatic advance_cursor(input t_op op, input logic [HEAD_W-1:0] head,
                                  input logic [CNT_W-1:0] req, output t_result res);
        logic [63:0] cap;
        logic [63:0] mask;
        logic [63:0] start;
        logic [63:0] h;
        logic [63:0] delta;
        logic [63:0] u;
        logic [63:0] margin;
        logic [63:0] grant;
        logic [63:0] avail;
        int unsigned lg;
        res   = '0;
        lg    = (ring_log2 > MAX_LOG2) ? MAX_LOG2 : ring_log2;
        cap   = 64'd1 << lg;
        mask  = cap - 64'd1;
        start = {48'b0, tail} & mask;
        u     = '0;
        grant = '0;
        case (op)
            OP_HEAD: begin
                h             = {48'b0, head} & mask;
                delta         = (h - ({48'b0, producer_head} & mask)) & mask;
                producer_head = h[HEAD_W-1:0];
                written_bytes = written_bytes + delta;
                u             = unread_bytes();
                if (u > cap) begin
                    margin = cap >> 2;
                    if (margin == 0) begin
                        margin = 64'd1;
                    end
                    overrun_ctr    = overrun_ctr + 1;
                    tail           = HEAD_W'((h - margin) & mask);
                    consumed_bytes = written_bytes - margin;
                    u              = margin;
                    res.overrun_seen = 1'b1;
                    recoveries++;
                end
            end
            OP_CONSUME, OP_PEEK: begin
                avail = unread_bytes();
                if (avail > cap) begin
                    avail = cap;
                end
                grant = ({47'b0, req} > avail) ? avail : {47'b0, req};
                if (op == OP_CONSUME && grant != 0) begin
                    tail           = HEAD_W'((start + grant) & mask);
                    consumed_bytes = consumed_bytes + grant;
                end
            end
            default: begin
                clear_cursor();
            end
        endcase
        avail = unread_bytes();
        if (avail > cap) begin
            avail = cap;
        end
        res.unread_after_head = u[CNT_W-1:0];
        res.granted_count     = grant[CNT_W-1:0];
        res.start_index       = start[HEAD_W-1:0];
        res.available_now     = avail[CNT_W-1:0];
        res.overrun_total     = overrun_ctr;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            ring_log2 = SIZE_LOG2_RST;
            clear_cursor();
            predicted_reports.delete();
            mismatches = 0;
            compared   = 0;
            recoveries = 0;
        end else begin
            if (i_cfg_wr_en) begin
                ring_log2 = i_cfg_wr_data;
            end
            // results first, so a word entering at the same edge cannot match
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                if (predicted_reports.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = predicted_reports.pop_front();
                    compared++;
                    check_field("unread_after_head", 32'(want.unread_after_head),
                                32'(got.unread_after_head));
                    check_field("granted_count", 32'(want.granted_count),
                                32'(got.granted_count));
                    check_field("start_index", 32'(want.start_index),
                                32'(got.start_index));
                    check_field("available_now", 32'(want.available_now),
                                32'(got.available_now));
                    check_field("overrun_seen", 32'(want.overrun_seen),
                                32'(got.overrun_seen));
                    check_field("overrun_total", want.overrun_total, got.overrun_total);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_cursor(t_op'(i_s_tuser), i_s_tdata[HEAD_W-1:0],
                               i_s_tdata[HEAD_W+CNT_W-1:HEAD_W], want);
                predicted_reports.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= predicted_reports.size();
        o_checked    <= compared;
        o_overruns   <= recoveries;
    end

endmodule

// File: bench/testbench.sv
// top of the ring read cursor bench: clock, reset, stimulus, verdict
// depends on rrco_pkg, ring_read_cursor_overrun_core and rrco_checker
module testbench;
    import rrco_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int overruns;

    bit          quiet         = 1'b0;
    bit          hold_request  = 1'b0;
    int unsigned ring_cap      = 4096;
    int unsigned head_pos      = 0;
    int          words_sent    = 0;
    int          sizes_used    = 1;

    logic [CFG_W-1:0] ring_sizes [12] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd31, 5'd17,
                                          5'd4, 5'd8, 5'd12, 5'd0, 5'd0, 5'd3};

    always #5 i_clk = ~i_clk;

    ring_read_cursor_overrun_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rrco_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_overruns    (overruns)
    );

    // offer one word, return right after the edge that takes it
    task automatic send_word(input t_op op, input logic [HEAD_W-1:0] head,
                             input logic [CNT_W-1:0] cnt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W-CNT_W-HEAD_W){1'b0}}, cnt, head};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] lg);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lg;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ring_cap = 1 << ((lg > MAX_SIZE_LOG2_DEF) ? MAX_SIZE_LOG2_DEF : lg);
        sizes_used++;
    endtask

    // mostly a producer moving ahead and a consumer chasing it, some noise
    task automatic random_word();
        int unsigned mask;
        int unsigned r;
        int unsigned k;
        logic [CNT_W-1:0] cnt;
        mask = ring_cap - 1;
        r    = $urandom_range(0, 99);
        k    = $urandom_range(0, 9);
        if (r < 42) begin
            if (k < 5) begin
                head_pos += $urandom_range(0, ring_cap / 2);
            end else if (k < 8) begin
                head_pos += $urandom_range(ring_cap / 2, ring_cap - 1);
            end else begin
                head_pos = $urandom;
            end
            send_word(OP_HEAD, HEAD_W'((head_pos & mask) | ($urandom & ~mask)),
                      CNT_W'($urandom_range(0, 65536)));
        end else if (r < 96) begin
            case (k)
                0:       cnt = '0;
                1:       cnt = 17'h10000;
                2, 3:    cnt = CNT_W'($urandom_range(0, 65536));
                default: cnt = CNT_W'($urandom_range(1, ring_cap));
            endcase
            send_word((r < 80) ? OP_CONSUME : OP_PEEK, HEAD_W'($urandom), cnt);
        end else begin
            send_word(OP_CLEAR, HEAD_W'($urandom), CNT_W'($urandom_range(0, 65536)));
            head_pos = 0;
        end
    endtask

    // sink side: random stalls, one long hold-off when asked
    initial begin
        int stall;
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #4_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner cases at the reset ring size of 4096 bytes
        send_word(OP_PEEK,    16'h0000, 17'd0);
        send_word(OP_CONSUME, 16'h0000, 17'h10000);
        send_word(OP_HEAD,    16'h0064, 17'd0);
        send_word(OP_PEEK,    16'h0000, 17'd50);
        send_word(OP_CONSUME, 16'hffff, 17'd0);
        send_word(OP_CONSUME, 16'h0000, 17'd30);
        send_word(OP_CONSUME, 16'h0000, 17'h10000);
        send_word(OP_HEAD,    16'hffff, 17'h1ffff & 17'h10000);
        send_word(OP_HEAD,    16'h0000, 17'd0);
        send_word(OP_HEAD,    16'h07d0, 17'd0);
        send_word(OP_PEEK,    16'h0000, 17'h10000);
        send_word(OP_CONSUME, 16'h0000, 17'h0ffff);
        send_word(OP_HEAD,    16'haaaa, 17'h0aaaa);
        send_word(OP_HEAD,    16'h5555, 17'h05555);
        send_word(OP_PEEK,    16'h0000, 17'h0ffff);
        send_word(OP_CONSUME, 16'h0000, 17'd1);
        send_word(OP_HEAD,    16'h1fff, 17'd0);
        send_word(OP_HEAD,    16'h3ffe, 17'd0);
        send_word(OP_CLEAR,   16'hffff, 17'h10000);
        send_word(OP_PEEK,    16'h0000, 17'd1);
        send_word(OP_HEAD,    16'h0800, 17'd0);
        send_word(OP_CONSUME, 16'h0000, 17'h00800);

        for (int p = 0; p < 12; p++) begin
            write_ring_size((p == 9 || p == 10) ? CFG_W'($urandom_range(0, 31))
                                                : ring_sizes[p]);
            quiet = (p % 4 == 1);
            if (p == 2 || p == 7) begin
                quiet        = 1'b1;
                hold_request = 1'b1;
            end
            repeat (160) random_word();
            quiet = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < 5000 && pending != 0; n++) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("covered %0d words: corner cases, then producer and consumer traffic",
                 words_sent);
        $display("%0d ring size settings, %0d results compared, %0d overrun recoveries",
                 sizes_used, checked, overruns);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/rrco_pkg.sv
design/rrco_in_stage.sv
design/rrco_cursor.sv
design/rrco_out_stage.sv
design/ring_read_cursor_overrun_core.sv
bench/rrco_checker.sv
bench/testbench.sv
